[rtl/rhc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_pkg
// Shared widths, constants and types of the RGB to HSV converter.
// ----------------------------------------------------------------------------
package rhc_pkg;

    // Channel and result widths
    localparam int CH_W       = 8;
    localparam int HUE_W      = 11;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 40;

    // Divider: numerator up to 256*255 + 254, quotient up to 256
    localparam int NUM_W      = 17;
    localparam int QUO_W      = 9;
    localparam int DIV_STAGES = 3;
    localparam int DIV_STEPS  = 3;

    // Sector bases in 1/256-sector units
    localparam logic [HUE_W-1:0] BASE_RED      = 11'd0;
    localparam logic [HUE_W-1:0] BASE_RED_WRAP = 11'd1536;
    localparam logic [HUE_W-1:0] BASE_GREEN    = 11'd512;
    localparam logic [HUE_W-1:0] BASE_BLUE     = 11'd1024;

    // Fields carried alongside the divider
    typedef struct packed {
        logic [HUE_W-1:0] hue_base;
        logic             hue_neg;
        logic [CH_W-1:0]  brightness;
        logic [CH_W-1:0]  alpha;
    } rhc_side_t;

    // Operands handed from the prep stage to the two dividers
    typedef struct packed {
        logic [NUM_W-1:0] hue_num;
        logic [CH_W-1:0]  hue_den;
        logic [NUM_W-1:0] sat_num;
        logic [CH_W-1:0]  sat_den;
    } rhc_oper_t;

    // One finished result
    typedef struct packed {
        logic [CH_W-1:0]  alpha_out;
        logic [CH_W-1:0]  brightness;
        logic [CH_W-1:0]  saturation;
        logic [HUE_W-1:0] hue;
    } rhc_result_t;

endpackage

[rtl/rhc_prep.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_prep
// First pipeline stage: max/min, sector choice and divider operands.
// ----------------------------------------------------------------------------
module rhc_prep (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [rhc_pkg::CH_W-1:0]   red,
    input  logic [rhc_pkg::CH_W-1:0]   green,
    input  logic [rhc_pkg::CH_W-1:0]   blue,
    input  logic [rhc_pkg::CH_W-1:0]   alpha,
    output logic                       out_valid,
    output rhc_pkg::rhc_side_t         out_side,
    output rhc_pkg::rhc_oper_t         out_oper
);

    logic [rhc_pkg::CH_W-1:0]  mx, mn, delta, pos, neg, diff;
    logic                      is_neg;
    logic [rhc_pkg::HUE_W-1:0] base;
    logic [rhc_pkg::NUM_W-1:0] hue_num, sat_num, wrap_adj;

    logic                      valid_reg;
    rhc_pkg::rhc_side_t        side_reg, side_next;
    rhc_pkg::rhc_oper_t        oper_reg, oper_next;

    // Largest and smallest channel
    always_comb begin
        mx = red;
        mn = red;
        if (green > mx) mx = green;
        if (blue > mx)  mx = blue;
        if (green < mn) mn = green;
        if (blue < mn)  mn = blue;
        delta = mx - mn;
    end

    // Sector: red tested first, then green, then blue
    always_comb begin
        if (mx == red) begin
            pos = green;
            neg = blue;
        end else if (mx == green) begin
            pos = blue;
            neg = red;
        end else begin
            pos = red;
            neg = green;
        end
        is_neg = (pos < neg);
        diff   = is_neg ? (neg - pos) : (pos - neg);
        if (mx == red) begin
            base = is_neg ? rhc_pkg::BASE_RED_WRAP : rhc_pkg::BASE_RED;
        end else if (mx == green) begin
            base = rhc_pkg::BASE_GREEN;
        end else begin
            base = rhc_pkg::BASE_BLUE;
        end
    end

    // Numerators; negative offsets round up, so add delta-1 before the floor
    always_comb begin
        wrap_adj = is_neg ? {{(rhc_pkg::NUM_W-rhc_pkg::CH_W){1'b0}}, delta - 8'd1} : '0;
        hue_num  = {1'b0, diff, 8'd0} + wrap_adj;
        sat_num  = {1'b0, delta, 8'd0} - {{(rhc_pkg::NUM_W-rhc_pkg::CH_W){1'b0}}, delta};
    end

    // Zero divisors only meet zero numerators; divide by one instead
    always_comb begin
        side_next.hue_base   = base;
        side_next.hue_neg    = is_neg;
        side_next.brightness = mx;
        side_next.alpha      = alpha;
        oper_next.hue_num    = hue_num;
        oper_next.hue_den    = (delta == 8'd0) ? 8'd1 : delta;
        oper_next.sat_num    = sat_num;
        oper_next.sat_den    = (mx == 8'd0) ? 8'd1 : mx;
    end

    // Stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg <= side_next;
            oper_reg <= oper_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_oper  = oper_reg;

endmodule

[rtl/rhc_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_div
// Pipelined restoring divider, a few quotient bits per register stage.
// ----------------------------------------------------------------------------
module rhc_div (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [rhc_pkg::NUM_W-1:0]   num,
    input  logic [rhc_pkg::CH_W-1:0]    den,
    output logic [rhc_pkg::QUO_W-1:0]   quo
);

    localparam int NW    = rhc_pkg::NUM_W;
    localparam int QW    = rhc_pkg::QUO_W;
    localparam int DW    = rhc_pkg::CH_W;
    localparam int NST   = rhc_pkg::DIV_STAGES;
    localparam int STEPS = rhc_pkg::DIV_STEPS;
    localparam int LAST  = NST - 1;

    logic [NW-1:0] rem_in  [NST];
    logic [DW-1:0] den_in  [NST];
    logic [QW-1:0] quo_in  [NST];
    logic [NW-1:0] rem_reg [LAST];
    logic [DW-1:0] den_reg [LAST];
    logic [QW-1:0] quo_reg [NST];

    for (genvar k = 0; k < NST; k++) begin : g_stage
        localparam int TOP_BIT = QW - 1 - k * STEPS;

        logic [NW-1:0] rem_next;
        logic [QW-1:0] quo_next;

        // Stage inputs
        if (k == 0) begin : g_first
            assign rem_in[k] = num;
            assign den_in[k] = den;
            assign quo_in[k] = '0;
        end else begin : g_chain
            assign rem_in[k] = rem_reg[k-1];
            assign den_in[k] = den_reg[k-1];
            assign quo_in[k] = quo_reg[k-1];
        end

        // Compare-subtract steps, one quotient bit each
        always_comb begin
            logic [NW-1:0] rem_v;
            logic [NW-1:0] sub_v;
            logic [QW-1:0] quo_v;
            rem_v = rem_in[k];
            quo_v = quo_in[k];
            for (int j = 0; j < STEPS; j++) begin
                sub_v = NW'(den_in[k]) << (TOP_BIT - j);
                if (rem_v >= sub_v) begin
                    rem_v              = rem_v - sub_v;
                    quo_v[TOP_BIT - j] = 1'b1;
                end
            end
            rem_next = rem_v;
            quo_next = quo_v;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                quo_reg[k] <= quo_next;
            end
        end

        // Partial remainder and divisor go on to the next stage
        if (k < LAST) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k] <= rem_next;
                    den_reg[k] <= den_in[k];
                end
            end
        end
    end

    assign quo = quo_reg[LAST];

endmodule

[rtl/rhc_skid.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_skid
// Output register with one skid entry; freezes the pipeline only when full.
// ----------------------------------------------------------------------------
module rhc_skid (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    input  rhc_pkg::rhc_result_t  in_data,
    output logic                  pipe_en,
    output logic                  m_valid,
    input  logic                  m_ready,
    output rhc_pkg::rhc_result_t  m_data
);

    logic                 out_valid_reg, out_valid_next;
    logic                 skid_valid_reg, skid_valid_next;
    rhc_pkg::rhc_result_t out_data_reg, out_data_next;
    rhc_pkg::rhc_result_t skid_data_reg, skid_data_next;
    logic                 arrive, take;

    // Pipeline runs whenever the skid entry is free
    assign pipe_en = !skid_valid_reg;
    assign arrive  = pipe_en && in_valid;
    assign take    = out_valid_reg && m_ready;

    // Next state of output and skid entries
    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (take) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (arrive) begin
            if (!out_valid_reg || take) begin
                out_data_next  = in_data;
                out_valid_next = 1'b1;
            end else begin
                skid_data_next  = in_data;
                skid_valid_next = 1'b1;
            end
        end else if (take) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

[rtl/rgb_to_hsv_converter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// Converts one RGBA pixel per clock, while the output is not stalled, into hue, saturation, value and alpha.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on the s_ stream (s_tvalid/s_tready/s_tdata); each accepted
//   transaction yields exactly one result transaction on the m_ stream, in
//   order. Hue is in 1/256-sector units (0..1535), saturation is
//   floor(255*delta/max), brightness is the largest channel, alpha passes.
//   Stages: an accepted pixel passes the prep stage, three divider stages of
//   three quotient bits each and the output register. Throughput: one pixel
//   per clock while the output is not stalled, set by the pipelined restoring
//   dividers that each retire three quotient bits per stage.
//   Reset: aresetn low clears all valid bits; no result is presented and
//   s_tready is high on the first cycle after reset.
//   Stall: while m_tready is low the output register holds its result; one
//   more transaction lands in a skid entry, after which s_tready drops and
//   the whole pipeline freezes until the output is taken. Nothing is lost
//   or repeated.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // red[7:0], green[15:8], blue[23:16], alpha[31:24]
    input  logic [rhc_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // hue[10:0], saturation[18:11], brightness[26:19], alpha_out[34:27], zero[39:35]
    output logic [rhc_pkg::OUT_DATA_W-1:0]   m_tdata
);

    localparam int NST  = rhc_pkg::DIV_STAGES;
    localparam int LAST = NST - 1;

    logic                          pipe_en;
    logic                          prep_valid;
    rhc_pkg::rhc_side_t            prep_side;
    rhc_pkg::rhc_oper_t            prep_oper;
    logic                          valid_reg [NST];
    rhc_pkg::rhc_side_t            side_reg  [NST];
    logic [rhc_pkg::QUO_W-1:0]     hue_quo, sat_quo;
    rhc_pkg::rhc_result_t          result, out_result;
    rhc_pkg::rhc_side_t            side_last;

    assign s_tready = pipe_en;

    // Stage 1: max/min, sector and operands
    rhc_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (s_tvalid),
        .red       (s_tdata[7:0]),
        .green     (s_tdata[15:8]),
        .blue      (s_tdata[23:16]),
        .alpha     (s_tdata[31:24]),
        .out_valid (prep_valid),
        .out_side  (prep_side),
        .out_oper  (prep_oper)
    );

    // Stages 2-4: hue fraction and saturation dividers
    rhc_div u_hue_div (
        .aclk (aclk),
        .en   (pipe_en),
        .num  (prep_oper.hue_num),
        .den  (prep_oper.hue_den),
        .quo  (hue_quo)
    );

    rhc_div u_sat_div (
        .aclk (aclk),
        .en   (pipe_en),
        .num  (prep_oper.sat_num),
        .den  (prep_oper.sat_den),
        .quo  (sat_quo)
    );

    // Valid bits and sideband fields follow the divider stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NST; k++) begin
                valid_reg[k] <= 1'b0;
            end
        end else if (pipe_en) begin
            valid_reg[0] <= prep_valid;
            for (int k = 1; k < NST; k++) begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            side_reg[0] <= prep_side;
            for (int k = 1; k < NST; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // Hue from sector base and rounded fraction
    assign side_last = side_reg[LAST];

    always_comb begin
        if (side_last.hue_neg) begin
            result.hue = side_last.hue_base - rhc_pkg::HUE_W'(hue_quo);
        end else begin
            result.hue = side_last.hue_base + rhc_pkg::HUE_W'(hue_quo);
        end
        result.saturation = sat_quo[rhc_pkg::CH_W-1:0];
        result.brightness = side_last.brightness;
        result.alpha_out  = side_last.alpha;
    end

    // Output register and skid entry
    rhc_skid u_skid (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (valid_reg[LAST]),
        .in_data  (result),
        .pipe_en  (pipe_en),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_data   (out_result)
    );

    assign m_tdata = {5'd0, out_result.alpha_out, out_result.brightness,
                      out_result.saturation, out_result.hue};

endmodule

[rtl/rhc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_checker
// Port-level assertions for the RGB to HSV converter, bound to the top level.
// ----------------------------------------------------------------------------
module rhc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    // A waiting input transaction holds its pixel
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("input changed while waiting");

    // A stalled result transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Hue stays within six sectors
    a_hue_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[10:0] <= 11'd1535)
        else $error("hue out of range");

    // Black pixel gives zero saturation and hue
    a_black: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[26:19] == 8'd0 |-> m_tdata[18:0] == 19'd0)
        else $error("black pixel with nonzero hue or saturation");

    // A taken output frees the skid entry, so input is accepted next cycle
    a_ready_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |=> s_tready)
        else $error("input stalled although output was taken");

endmodule

bind rgb_to_hsv_converter rhc_checker u_rhc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
